// ===== design/iol_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the indexed ordered list: command and status codes, cell control word.
// No dependencies; used by the interfaces, the cell and the top level.
package iol_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int POS_W = 4;
	localparam int VAL_W = 32;
	localparam int CNT_W = 5;
	localparam int CMD_W = 3;
	localparam int ST_W = 2;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DROP = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ = 3'd4;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic app;
		logic ins;
		logic rem;
		logic [POS_W-1:0] pos;
		logic signed [VAL_W-1:0] val;
	} iol_op_t;

endpackage
`default_nettype wire

// ===== design/iol_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Handshake channels of the indexed ordered list: command word in, result word out.
// Depends on iol_pkg.
interface iol_cmd_if;
	logic valid;
	logic ready;
	logic [iol_pkg::CMD_W-1:0] cmd;
	logic [iol_pkg::POS_W-1:0] position;
	logic signed [iol_pkg::VAL_W-1:0] value_in;

	modport source (output valid, cmd, position, value_in, input ready);
	modport sink (input valid, cmd, position, value_in, output ready);
endinterface

interface iol_res_if;
	logic valid;
	logic ready;
	logic signed [iol_pkg::VAL_W-1:0] value_out;
	logic [iol_pkg::CNT_W-1:0] count;
	logic [iol_pkg::ST_W-1:0] status;

	modport source (output valid, value_out, count, status, input ready);
	modport sink (input valid, value_out, count, status, output ready);
endinterface
`default_nettype wire

// ===== design/iol_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One storage cell of the list chain: holds one element, loads the new value
// or takes its left or right neighbour on insert, append and remove. Uses iol_pkg.
module iol_cell #(
	parameter int INDEX = 0,
	parameter int FILL_W = 5
) (
	input  wire logic clk,
	input  wire iol_pkg::iol_op_t op,
	input  wire logic [FILL_W-1:0] fill,
	input  wire logic signed [iol_pkg::VAL_W-1:0] left,
	input  wire logic signed [iol_pkg::VAL_W-1:0] right,
	output logic signed [iol_pkg::VAL_W-1:0] value
);
	import iol_pkg::*;

	localparam int CW = (FILL_W > POS_W) ? FILL_W : POS_W;
	localparam logic [CW-1:0] IDX = CW'(INDEX);
	localparam logic [CW-1:0] IDX_NXT = CW'(INDEX + 1);

	logic [CW-1:0] pos_x;
	logic [CW-1:0] fill_x;
	logic signed [VAL_W-1:0] val_q;

	assign pos_x = CW'(op.pos);
	assign fill_x = CW'(fill);

	always_ff @(posedge clk) begin
		if (op.app && IDX == fill_x) begin
			val_q <= op.val;
		end else if (op.ins && IDX == pos_x) begin
			val_q <= op.val;
		end else if (op.ins && IDX > pos_x && IDX <= fill_x) begin
			val_q <= left;
		end else if (op.rem && IDX >= pos_x && IDX_NXT < fill_x) begin
			val_q <= right;
		end
	end

	assign value = val_q;

endmodule
`default_nettype wire

// ===== design/indexed_ordered_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the indexed ordered list: command decode, element count, chain
// of cells and registered result word. Depends on iol_pkg, iol_if and iol_cell.
//
// Ordered list of up to CAPACITY signed 32-bit elements held in a chain of cells.
// Each command word (append, drop last, insert at, remove at, read at) is done on
// the edge that accepts it: the cells shift towards or away from a neighbour, so
// the command is accepted whenever the result register is empty or being drained,
// giving one word per cycle while the result side keeps up. Every command gives one
// result word with the read value (zero unless a read succeeded), the element count
// after the command and a status: ok, index out of range, list full or list empty.
// Refused commands leave the list untouched. Unknown commands return ok and do
// nothing. Only the first sixteen elements can be addressed by index; count is the
// element count truncated to five bits. No clearing pass is needed after reset.
module indexed_ordered_list #(
	parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	iol_cmd_if.sink   req,
	iol_res_if.source rsp
);
	import iol_pkg::*;

	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam int CW = (FILL_W > POS_W) ? FILL_W : POS_W;
	localparam int RD_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_d;
	logic rsp_valid_q;
	logic signed [VAL_W-1:0] value_q;
	logic [CNT_W-1:0] count_q;
	logic [ST_W-1:0] status_q;

	logic accept;
	logic is_empty;
	logic is_full;
	logic [CW-1:0] pos_x;
	logic [CW-1:0] fill_x;
	logic [ST_W-1:0] st_d;
	logic signed [VAL_W-1:0] rd_d;
	logic signed [VAL_W-1:0] rd_mux;
	iol_op_t op;
	logic signed [VAL_W-1:0] vals [CAPACITY];

	assign accept = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;

	assign is_empty = (fill_q == '0);
	assign is_full = (fill_q == FILL_W'(CAPACITY));
	assign pos_x = CW'(req.position);
	assign fill_x = CW'(fill_q);

	// read select over the addressable cells
	always_comb begin
		rd_mux = '0;
		for (int i = 0; i < RD_N; i++) begin
			if (req.position == POS_W'(i)) begin
				rd_mux = vals[i];
			end
		end
	end

	always_comb begin
		op.app = 1'b0;
		op.ins = 1'b0;
		op.rem = 1'b0;
		op.pos = req.position;
		op.val = req.value_in;
		st_d = ST_OK;
		rd_d = '0;
		fill_d = fill_q;
		unique case (req.cmd)
			CMD_APPEND: begin
				if (is_full) begin
					st_d = ST_FULL;
				end else begin
					op.app = accept;
					fill_d = fill_q + 1'b1;
				end
			end
			CMD_DROP: begin
				if (is_empty) begin
					st_d = ST_EMPTY;
				end else begin
					fill_d = fill_q - 1'b1;
				end
			end
			CMD_INSERT: begin
				if (pos_x > fill_x) begin
					st_d = ST_RANGE;
				end else if (is_full) begin
					st_d = ST_FULL;
				end else begin
					op.ins = accept;
					fill_d = fill_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (is_empty) begin
					st_d = ST_EMPTY;
				end else if (pos_x >= fill_x) begin
					st_d = ST_RANGE;
				end else begin
					op.rem = accept;
					fill_d = fill_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (is_empty) begin
					st_d = ST_EMPTY;
				end else if (pos_x >= fill_x) begin
					st_d = ST_RANGE;
				end else begin
					rd_d = rd_mux;
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [VAL_W-1:0] left;
		logic signed [VAL_W-1:0] right;
		if (k == 0) begin : g_first
			assign left = '0;
		end else begin : g_left
			assign left = vals[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_right
			assign right = vals[k+1];
		end
		iol_cell #(
			.INDEX (k),
			.FILL_W(FILL_W)
		) u_cell (
			.clk  (clk),
			.op   (op),
			.fill (fill_q),
			.left (left),
			.right(right),
			.value(vals[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= rd_d;
			count_q <= CNT_W'(fill_d);
			status_q <= st_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.value_out = value_q;
	assign rsp.count = count_q;
	assign rsp.status = status_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CAPACITY))
		else $error("element count above capacity");

	a_drop_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.cmd == CMD_DROP && fill_q != '0 |=> fill_q == $past(fill_q) - 1'b1)
		else $error("drop did not lower the count");

	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.value_out != '0 |-> rsp.status == ST_OK)
		else $error("read value given with an error status");

	a_count_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.count == CNT_W'(fill_q))
		else $error("result count differs from element count");
`endif

endmodule
`default_nettype wire
